[rtl/core/mieu_pkg.sv]
// ---------------------------------------------------------------------------
// mieu_pkg
// Shared opcodes, function codes, exception codes, controller commands.
// ---------------------------------------------------------------------------
package mieu_pkg;

    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] REGION_MASK = 32'hF000_0000;

    localparam logic [2:0] EXC_NONE     = 3'd0;
    localparam logic [2:0] EXC_OVERFLOW = 3'd1;
    localparam logic [2:0] EXC_SYSCALL  = 3'd2;
    localparam logic [2:0] EXC_BREAK    = 3'd3;
    localparam logic [2:0] EXC_ILLEGAL  = 3'd4;
    localparam logic [2:0] EXC_COPROC   = 3'd5;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [5:0] OP_COP3    = 6'h13;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2A;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_SWR     = 6'h2E;
    localparam logic [5:0] OP_LWC0    = 6'h30;
    localparam logic [5:0] OP_LWC1    = 6'h31;
    localparam logic [5:0] OP_LWC2    = 6'h32;
    localparam logic [5:0] OP_LWC3    = 6'h33;
    localparam logic [5:0] OP_SWC0    = 6'h38;
    localparam logic [5:0] OP_SWC1    = 6'h39;
    localparam logic [5:0] OP_SWC2    = 6'h3A;
    localparam logic [5:0] OP_SWC3    = 6'h3B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture input and trigger decode
        logic mul_start;  // launch multiply sequence
        logic div_start;  // launch divide sequence
        logic step;       // advance one mul/div step
        logic finish;     // write HI/LO from mul/div unit
    } mieu_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic last_step;
    } mieu_status_t;

endpackage

[rtl/core/mieu_ctrl.sv]
// ---------------------------------------------------------------------------
// mieu_ctrl
// Handshake and sequencing controller for the execute unit.
// ---------------------------------------------------------------------------
module mieu_ctrl
    import mieu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    output mieu_cmd_t    cmd,
    input  mieu_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DEC  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       in_xfer, out_xfer;

    assign in_stall  = (state_reg != ST_IDLE) && !(state_reg == ST_OUT && !out_stall);
    assign out_valid = (state_reg == ST_OUT);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;

    // Drive commands and next state
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.load      = in_xfer;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.mul_start = status.is_mul;
                cmd.div_start = status.is_div;
                state_next = (status.is_mul || status.is_div) ? ST_RUN : ST_OUT;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_xfer)
                    state_next = in_xfer ? ST_DEC : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/mieu_dp.sv]
// ---------------------------------------------------------------------------
// mieu_dp
// Datapath: decode, ALU, branch unit, HI/LO, radix-2 multiply/divide unit.
// ---------------------------------------------------------------------------
module mieu_dp
    import mieu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mieu_cmd_t    cmd,
    output mieu_status_t status,
    input  logic [31:0]  instruction_word,
    input  logic [31:0]  rs_value,
    input  logic [31:0]  rt_value,
    input  logic [31:0]  sequential_pc,
    output logic         write_enable,
    output logic [4:0]   write_index,
    output logic [31:0]  write_value,
    output logic         is_control_transfer,
    output logic         redirect_taken,
    output logic [31:0]  next_fetch_pc,
    output logic [2:0]   exception_code,
    output logic         passed_on
);

    // Captured item
    logic [31:0] iw_reg, a_reg, b_reg, seq_reg;
    // HI/LO
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    // Result registers
    logic        we_reg, we_next;
    logic [4:0]  widx_reg, widx_next;
    logic [31:0] wval_reg, wval_next;
    logic        ctl_reg, ctl_next, tk_reg, tk_next;
    logic [31:0] npc_reg, npc_next;
    logic [2:0]  exc_reg, exc_next;
    logic        pass_reg, pass_next;
    // Mul/div unit
    logic [31:0] acc_reg, acc_next;   // partial product high / remainder
    logic [31:0] q_reg, q_next;       // multiplier / quotient
    logic [31:0] m_reg, m_next;       // multiplicand / divisor magnitude
    logic [4:0]  cnt_reg, cnt_next;
    logic        mdiv_reg, mdiv_next, neg_q_reg, neg_q_next, neg_r_reg, neg_r_next;
    logic        dz_reg, dz_next, dovf_reg, dovf_next;
    // Decode cycle marker
    logic        dec_now;
    logic        dec_reg;

    logic [5:0]  op, fn;
    logic [4:0]  rd, rt, sa;
    logic [15:0] imm;
    logic [31:0] simm, slot, btarget, jtarget, sum, diff, addi_v, sh_in, sra_fill;
    logic [4:0]  shamt;
    logic        a_neg, b_neg, cond;
    logic [32:0] mstep;
    logic [32:0] dtrial;
    logic [31:0] dshift;
    logic [63:0] mres;
    logic [31:0] absn, absd;

    assign op   = iw_reg[31:26];
    assign fn   = iw_reg[5:0];
    assign rd   = iw_reg[15:11];
    assign rt   = iw_reg[20:16];
    assign sa   = iw_reg[10:6];
    assign imm  = iw_reg[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign slot = seq_reg - 32'd4;
    assign btarget = slot + {simm[29:0], 2'b00};
    assign jtarget = (slot & REGION_MASK) | {4'b0, iw_reg[25:0], 2'b00};
    assign sum    = a_reg + b_reg;
    assign diff   = a_reg - b_reg;
    assign addi_v = a_reg + simm;
    assign a_neg  = a_reg[31];
    assign b_neg  = b_reg[31];
    assign shamt  = fn[2] ? a_reg[4:0] : sa;
    assign sh_in  = b_reg;
    assign sra_fill = ~(ALL_ONES >> shamt);
    assign absn   = a_neg ? (32'd0 - a_reg) : a_reg;
    assign absd   = b_neg ? (32'd0 - b_reg) : b_reg;

    assign status.is_mul = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU);
    assign status.is_div = (op == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU);
    assign status.last_step = (cnt_reg == 5'd31);

    // One step of shift-add multiply / restoring divide
    assign mstep  = {1'b0, acc_reg} + (q_reg[0] ? {1'b0, m_reg} : 33'd0);
    assign dshift = {acc_reg[30:0], q_reg[31]};
    assign dtrial = {acc_reg[31], dshift} - {1'b0, m_reg};
    assign mres   = {mstep[32:1], mstep[0], q_reg[31:1]};

    // Decode the result of ordinary instructions and sequence the mul/div unit
    always_comb
    begin
        we_next = we_reg; widx_next = widx_reg; wval_next = wval_reg;
        ctl_next = ctl_reg; tk_next = tk_reg; npc_next = npc_reg;
        exc_next = exc_reg; pass_next = pass_reg;
        hi_next = hi_reg; lo_next = lo_reg;
        acc_next = acc_reg; q_next = q_reg; m_next = m_reg; cnt_next = cnt_reg;
        mdiv_next = mdiv_reg; neg_q_next = neg_q_reg; neg_r_next = neg_r_reg;
        dz_next = dz_reg; dovf_next = dovf_reg;
        cond = 1'b0;

        if (cmd.mul_start)
        begin
            mdiv_next  = 1'b0;
            acc_next   = '0;
            q_next     = b_reg;
            m_next     = a_reg;
            cnt_next   = '0;
        end
        if (cmd.div_start)
        begin
            mdiv_next  = 1'b1;
            acc_next   = '0;
            cnt_next   = '0;
            dz_next    = (b_reg == 32'd0);
            dovf_next  = (fn == FN_DIV) && (a_reg == SIGN_BIT) && (b_reg == ALL_ONES);
            if (fn == FN_DIV)
            begin
                q_next = absn; m_next = absd;
                neg_q_next = a_neg ^ b_neg; neg_r_next = a_neg;
            end
            else
            begin
                q_next = a_reg; m_next = b_reg;
                neg_q_next = 1'b0; neg_r_next = 1'b0;
            end
        end

        if (cmd.step)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (!mdiv_reg)
            begin
                acc_next = mres[63:32];
                q_next   = mres[31:0];
            end
            else if (!dtrial[32])
            begin
                acc_next = dtrial[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                acc_next = dshift;
                q_next   = {q_reg[30:0], 1'b0};
            end
        end

        if (cmd.finish)
        begin
            if (!mdiv_reg)
            begin
                hi_next = mres[63:32];
                lo_next = mres[31:0];
                if (fn == FN_MULT)
                    hi_next = mres[63:32] - (a_neg ? b_reg : 32'd0)
                              - (b_neg ? a_reg : 32'd0);
            end
            else if (dz_reg)
            begin
                hi_next = a_reg;
                lo_next = (fn == FN_DIV && a_neg) ? 32'd1 : ALL_ONES;
            end
            else if (dovf_reg)
            begin
                hi_next = '0;
                lo_next = SIGN_BIT;
            end
            else
            begin
                hi_next = neg_r_reg ? (32'd0 - acc_next) : acc_next;
                lo_next = neg_q_reg ? (32'd0 - q_next) : q_next;
            end
        end

        // Decode when the item sits in DEC (mul/div_start marks DEC too)
        if (cmd.mul_start || cmd.div_start || dec_now)
        begin
            we_next = 1'b0; widx_next = '0; wval_next = '0;
            ctl_next = 1'b0; tk_next = 1'b0; npc_next = seq_reg;
            exc_next = EXC_NONE; pass_next = 1'b0;
            case (op)
                OP_SPECIAL:
                begin
                    case (fn)
                        FN_SLL, FN_SLLV:
                        begin we_next = 1'b1; widx_next = rd; wval_next = sh_in << shamt; end
                        FN_SRL, FN_SRLV:
                        begin we_next = 1'b1; widx_next = rd; wval_next = sh_in >> shamt; end
                        FN_SRA, FN_SRAV:
                        begin
                            we_next = 1'b1; widx_next = rd;
                            wval_next = (sh_in >> shamt) | (sh_in[31] ? sra_fill : 32'd0);
                        end
                        FN_JR:
                        begin ctl_next = 1'b1; tk_next = 1'b1; npc_next = a_reg; end
                        FN_JALR:
                        begin
                            we_next = 1'b1; widx_next = rd; wval_next = seq_reg;
                            ctl_next = 1'b1; tk_next = 1'b1; npc_next = a_reg;
                        end
                        FN_SYSCALL: exc_next = EXC_SYSCALL;
                        FN_BREAK:   exc_next = EXC_BREAK;
                        FN_MFHI:
                        begin we_next = 1'b1; widx_next = rd; wval_next = hi_reg; end
                        FN_MTHI: hi_next = a_reg;
                        FN_MFLO:
                        begin we_next = 1'b1; widx_next = rd; wval_next = lo_reg; end
                        FN_MTLO: lo_next = a_reg;
                        FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: ;
                        FN_ADD:
                        begin
                            if (((a_reg ^ sum) & (b_reg ^ sum) & SIGN_BIT) != 32'd0)
                                exc_next = EXC_OVERFLOW;
                            else
                            begin we_next = 1'b1; widx_next = rd; wval_next = sum; end
                        end
                        FN_ADDU:
                        begin we_next = 1'b1; widx_next = rd; wval_next = sum; end
                        FN_SUB:
                        begin
                            if (((a_reg ^ b_reg) & (a_reg ^ diff) & SIGN_BIT) != 32'd0)
                                exc_next = EXC_OVERFLOW;
                            else
                            begin we_next = 1'b1; widx_next = rd; wval_next = diff; end
                        end
                        FN_SUBU:
                        begin we_next = 1'b1; widx_next = rd; wval_next = diff; end
                        FN_AND:
                        begin we_next = 1'b1; widx_next = rd; wval_next = a_reg & b_reg; end
                        FN_OR:
                        begin we_next = 1'b1; widx_next = rd; wval_next = a_reg | b_reg; end
                        FN_XOR:
                        begin we_next = 1'b1; widx_next = rd; wval_next = a_reg ^ b_reg; end
                        FN_NOR:
                        begin we_next = 1'b1; widx_next = rd; wval_next = ~(a_reg | b_reg); end
                        FN_SLT:
                        begin
                            we_next = 1'b1; widx_next = rd;
                            wval_next = {31'd0, $signed(a_reg) < $signed(b_reg)};
                        end
                        FN_SLTU:
                        begin
                            we_next = 1'b1; widx_next = rd;
                            wval_next = {31'd0, a_reg < b_reg};
                        end
                        default: exc_next = EXC_ILLEGAL;
                    endcase
                end
                OP_REGIMM:
                begin
                    cond = iw_reg[16] ? !a_neg : a_neg;
                    if (iw_reg[20])
                    begin we_next = 1'b1; widx_next = 5'd31; wval_next = seq_reg; end
                    ctl_next = 1'b1; tk_next = cond;
                    npc_next = cond ? btarget : seq_reg;
                end
                OP_J:
                begin ctl_next = 1'b1; tk_next = 1'b1; npc_next = jtarget; end
                OP_JAL:
                begin
                    we_next = 1'b1; widx_next = 5'd31; wval_next = seq_reg;
                    ctl_next = 1'b1; tk_next = 1'b1; npc_next = jtarget;
                end
                OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ:
                begin
                    case (op)
                        OP_BEQ:  cond = (a_reg == b_reg);
                        OP_BNE:  cond = (a_reg != b_reg);
                        OP_BLEZ: cond = (a_reg == 32'd0) || a_neg;
                        default: cond = (a_reg != 32'd0) && !a_neg;
                    endcase
                    ctl_next = 1'b1; tk_next = cond;
                    npc_next = cond ? btarget : seq_reg;
                end
                OP_ADDI:
                begin
                    if (((a_reg ^ addi_v) & (simm ^ addi_v) & SIGN_BIT) != 32'd0)
                        exc_next = EXC_OVERFLOW;
                    else
                    begin we_next = 1'b1; widx_next = rt; wval_next = addi_v; end
                end
                OP_ADDIU:
                begin we_next = 1'b1; widx_next = rt; wval_next = addi_v; end
                OP_SLTI:
                begin
                    we_next = 1'b1; widx_next = rt;
                    wval_next = {31'd0, $signed(a_reg) < $signed(simm)};
                end
                OP_SLTIU:
                begin we_next = 1'b1; widx_next = rt; wval_next = {31'd0, a_reg < simm}; end
                OP_ANDI:
                begin we_next = 1'b1; widx_next = rt; wval_next = a_reg & {16'd0, imm}; end
                OP_ORI:
                begin we_next = 1'b1; widx_next = rt; wval_next = a_reg | {16'd0, imm}; end
                OP_XORI:
                begin we_next = 1'b1; widx_next = rt; wval_next = a_reg ^ {16'd0, imm}; end
                OP_LUI:
                begin we_next = 1'b1; widx_next = rt; wval_next = {imm, 16'd0}; end
                OP_COP0, OP_COP2, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
                OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_LWC2, OP_SWC2:
                    pass_next = 1'b1;
                OP_COP1, OP_COP3, OP_LWC0, OP_LWC1, OP_LWC3, OP_SWC0, OP_SWC1, OP_SWC3:
                    exc_next = EXC_COPROC;
                default: exc_next = EXC_ILLEGAL;
            endcase
        end
    end

    // Mark the decode cycle: the cycle after capture
    assign dec_now = dec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= 1'b0;
            hi_reg  <= '0;
            lo_reg  <= '0;
        end
        else
        begin
            dec_reg <= cmd.load;
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            iw_reg  <= instruction_word;
            a_reg   <= rs_value;
            b_reg   <= rt_value;
            seq_reg <= sequential_pc;
        end
        we_reg <= we_next; widx_reg <= widx_next; wval_reg <= wval_next;
        ctl_reg <= ctl_next; tk_reg <= tk_next; npc_reg <= npc_next;
        exc_reg <= exc_next; pass_reg <= pass_next;
        acc_reg <= acc_next; q_reg <= q_next; m_reg <= m_next; cnt_reg <= cnt_next;
        mdiv_reg <= mdiv_next; neg_q_reg <= neg_q_next; neg_r_reg <= neg_r_next;
        dz_reg <= dz_next; dovf_reg <= dovf_next;
    end

    assign write_enable        = we_reg;
    assign write_index         = widx_reg;
    assign write_value         = wval_reg;
    assign is_control_transfer = ctl_reg;
    assign redirect_taken      = tk_reg;
    assign next_fetch_pc       = npc_reg;
    assign exception_code      = exc_reg;
    assign passed_on           = pass_reg;

endmodule

[rtl/core/mips_integer_execute_unit.sv]
// ---------------------------------------------------------------------------
// mips_integer_execute_unit
// Integer execute stage of an R3000-class core with HI/LO and mul/div.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | instruction_word, rs_value, rt_value, sequential_pc
//  out     | out_valid / out_stall| write_enable .. passed_on
//
//  Ordinary instructions: after the input transfer, decode in DEC registers the result for OUT.
//  MULT/MULTU/DIV/DIVU: decode in DEC, then 32 radix-2 steps in RUN, then the result in OUT.
//  in_stall stays high from a transfer until its result transfers; a new item is
//  taken in the same cycle the previous result transfers.
//  Reset clears control state and HI/LO to zero.
//  Result holds while out_stall is high.
module mips_integer_execute_unit
    import mieu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction_word,
    input  logic [31:0] rs_value,
    input  logic [31:0] rt_value,
    input  logic [31:0] sequential_pc,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_enable,
    output logic [4:0]  write_index,
    output logic [31:0] write_value,
    output logic        is_control_transfer,
    output logic        redirect_taken,
    output logic [31:0] next_fetch_pc,
    output logic [2:0]  exception_code,
    output logic        passed_on
);

    mieu_cmd_t    cmd;
    mieu_status_t status;

    mieu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    mieu_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .instruction_word    (instruction_word),
        .rs_value            (rs_value),
        .rt_value            (rt_value),
        .sequential_pc       (sequential_pc),
        .write_enable        (write_enable),
        .write_index         (write_index),
        .write_value         (write_value),
        .is_control_transfer (is_control_transfer),
        .redirect_taken      (redirect_taken),
        .next_fetch_pc       (next_fetch_pc),
        .exception_code      (exception_code),
        .passed_on           (passed_on)
    );

endmodule

[rtl/core/mieu_checker.sv]
// ---------------------------------------------------------------------------
// mieu_checker
// Port-level checks for the execute unit.
// ---------------------------------------------------------------------------
module mieu_checker
    import mieu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        write_enable,
    input logic        is_control_transfer,
    input logic        redirect_taken,
    input logic [2:0]  exception_code,
    input logic        passed_on
);

    // Hold result while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Taken implies control transfer
    a_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && redirect_taken |-> is_control_transfer)
        else $error("taken without transfer");

    // Exception or pass-on writes nothing
    a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (exception_code != EXC_NONE || passed_on) |-> !write_enable)
        else $error("write on exception");

    // Exception code in range
    a_exc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> exception_code <= EXC_COPROC)
        else $error("bad exception code");

    // An accepted instruction needs its decode cycle before any result shows
    a_decode_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result without decode cycle");

endmodule

bind mips_integer_execute_unit mieu_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .write_enable        (write_enable),
    .is_control_transfer (is_control_transfer),
    .redirect_taken      (redirect_taken),
    .exception_code      (exception_code),
    .passed_on           (passed_on)
);

[dv/mips_integer_execute_unit_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mips_integer_execute_unit_checker
// Watches both channels of the execute unit, predicts each result from the
// accepted instruction and its own HI/LO copy, and compares field by field.
// ---------------------------------------------------------------------------
module mips_integer_execute_unit_checker
    import mieu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] instruction_word,
    input  logic [31:0] rs_value,
    input  logic [31:0] rt_value,
    input  logic [31:0] sequential_pc,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        write_enable,
    input  logic [4:0]  write_index,
    input  logic [31:0] write_value,
    input  logic        is_control_transfer,
    input  logic        redirect_taken,
    input  logic [31:0] next_fetch_pc,
    input  logic [2:0]  exception_code,
    input  logic        passed_on,
    output int          error_count,
    output int          pending_count
);

    typedef struct packed {
        logic        we;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic        ctl;
        logic        taken;
        logic [31:0] npc;
        logic [2:0]  exc;
        logic        pass;
    } exec_outcome_t;

    exec_outcome_t expected_outcomes[$];
    logic [31:0]   hi_copy;
    logic [31:0]   lo_copy;

    // Compute the outcome of one instruction and update HI/LO
    function automatic exec_outcome_t execute_instr(input logic [31:0] w, input logic [31:0] a,
                                                    input logic [31:0] b, input logic [31:0] seq);
        exec_outcome_t r;
        logic [5:0]  op;
        logic [31:0] imm;
        logic [31:0] simm;
        logic [31:0] slot;
        logic [31:0] btgt;
        logic [31:0] jtgt;
        logic [31:0] v;
        logic [63:0] prod;
        logic [4:0]  rd;
        logic [4:0]  rt;
        logic [4:0]  sa;
        r    = '0;
        r.npc = seq;
        op   = w[31:26];
        rd   = w[15:11];
        rt   = w[20:16];
        sa   = w[10:6];
        imm  = {16'h0, w[15:0]};
        simm = {{16{w[15]}}, w[15:0]};
        slot = seq - 32'd4;
        btgt = slot + (simm << 2);
        jtgt = (slot & REGION_MASK) | {4'h0, w[25:0], 2'b00};
        case (op)
            OP_SPECIAL:
                case (w[5:0])
                    FN_SLL:     begin r.we = 1; r.widx = rd; r.wval = b << sa; end
                    FN_SRL:     begin r.we = 1; r.widx = rd; r.wval = b >> sa; end
                    FN_SRA:     begin r.we = 1; r.widx = rd; r.wval = $signed(b) >>> sa; end
                    FN_SLLV:    begin r.we = 1; r.widx = rd; r.wval = b << a[4:0]; end
                    FN_SRLV:    begin r.we = 1; r.widx = rd; r.wval = b >> a[4:0]; end
                    FN_SRAV:
                    begin
                        r.we = 1; r.widx = rd; r.wval = $signed(b) >>> a[4:0];
                    end
                    FN_JR:      begin r.ctl = 1; r.taken = 1; r.npc = a; end
                    FN_JALR:
                    begin
                        r.we = 1; r.widx = rd; r.wval = seq;
                        r.ctl = 1; r.taken = 1; r.npc = a;
                    end
                    FN_SYSCALL: r.exc = EXC_SYSCALL;
                    FN_BREAK:   r.exc = EXC_BREAK;
                    FN_MFHI:    begin r.we = 1; r.widx = rd; r.wval = hi_copy; end
                    FN_MTHI:    hi_copy = a;
                    FN_MFLO:    begin r.we = 1; r.widx = rd; r.wval = lo_copy; end
                    FN_MTLO:    lo_copy = a;
                    FN_MULT:
                    begin
                        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                        hi_copy = prod[63:32]; lo_copy = prod[31:0];
                    end
                    FN_MULTU:
                    begin
                        prod = {32'h0, a} * {32'h0, b};
                        hi_copy = prod[63:32]; lo_copy = prod[31:0];
                    end
                    FN_DIV:
                    begin
                        if (b == 32'h0)
                        begin
                            hi_copy = a; lo_copy = a[31] ? 32'd1 : ALL_ONES;
                        end
                        else if (a == SIGN_BIT && b == ALL_ONES)
                        begin
                            hi_copy = 32'h0; lo_copy = SIGN_BIT;
                        end
                        else
                        begin
                            lo_copy = $signed(a) / $signed(b);
                            hi_copy = $signed(a) % $signed(b);
                        end
                    end
                    FN_DIVU:
                    begin
                        if (b == 32'h0)
                        begin
                            hi_copy = a; lo_copy = ALL_ONES;
                        end
                        else
                        begin
                            lo_copy = a / b; hi_copy = a % b;
                        end
                    end
                    FN_ADD:
                    begin
                        v = a + b;
                        if (((a ^ v) & (b ^ v) & SIGN_BIT) != 0) r.exc = EXC_OVERFLOW;
                        else begin r.we = 1; r.widx = rd; r.wval = v; end
                    end
                    FN_ADDU:    begin r.we = 1; r.widx = rd; r.wval = a + b; end
                    FN_SUB:
                    begin
                        v = a - b;
                        if (((a ^ b) & (a ^ v) & SIGN_BIT) != 0) r.exc = EXC_OVERFLOW;
                        else begin r.we = 1; r.widx = rd; r.wval = v; end
                    end
                    FN_SUBU:    begin r.we = 1; r.widx = rd; r.wval = a - b; end
                    FN_AND:     begin r.we = 1; r.widx = rd; r.wval = a & b; end
                    FN_OR:      begin r.we = 1; r.widx = rd; r.wval = a | b; end
                    FN_XOR:     begin r.we = 1; r.widx = rd; r.wval = a ^ b; end
                    FN_NOR:     begin r.we = 1; r.widx = rd; r.wval = ~(a | b); end
                    FN_SLT:
                    begin
                        r.we = 1; r.widx = rd; r.wval = {31'h0, $signed(a) < $signed(b)};
                    end
                    FN_SLTU:    begin r.we = 1; r.widx = rd; r.wval = {31'h0, a < b}; end
                    default:    r.exc = EXC_ILLEGAL;
                endcase
            OP_REGIMM:
            begin
                if (w[20])
                begin
                    r.we = 1; r.widx = 5'd31; r.wval = seq;
                end
                r.ctl = 1;
                if (w[16] ? !a[31] : a[31])
                begin
                    r.taken = 1; r.npc = btgt;
                end
            end
            OP_J:   begin r.ctl = 1; r.taken = 1; r.npc = jtgt; end
            OP_JAL:
            begin
                r.we = 1; r.widx = 5'd31; r.wval = seq;
                r.ctl = 1; r.taken = 1; r.npc = jtgt;
            end
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ:
            begin
                r.ctl = 1;
                if ((op == OP_BEQ && a == b) || (op == OP_BNE && a != b) ||
                    (op == OP_BLEZ && (a == 0 || a[31])) ||
                    (op == OP_BGTZ && a != 0 && !a[31]))
                begin
                    r.taken = 1; r.npc = btgt;
                end
            end
            OP_ADDI:
            begin
                v = a + simm;
                if (((a ^ v) & (simm ^ v) & SIGN_BIT) != 0) r.exc = EXC_OVERFLOW;
                else begin r.we = 1; r.widx = rt; r.wval = v; end
            end
            OP_ADDIU: begin r.we = 1; r.widx = rt; r.wval = a + simm; end
            OP_SLTI:
            begin
                r.we = 1; r.widx = rt; r.wval = {31'h0, $signed(a) < $signed(simm)};
            end
            OP_SLTIU: begin r.we = 1; r.widx = rt; r.wval = {31'h0, a < simm}; end
            OP_ANDI:  begin r.we = 1; r.widx = rt; r.wval = a & imm; end
            OP_ORI:   begin r.we = 1; r.widx = rt; r.wval = a | imm; end
            OP_XORI:  begin r.we = 1; r.widx = rt; r.wval = a ^ imm; end
            OP_LUI:   begin r.we = 1; r.widx = rt; r.wval = imm << 16; end
            OP_COP0, OP_COP2, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
            OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_LWC2, OP_SWC2:
                r.pass = 1;
            OP_COP1, OP_COP3, OP_LWC0, OP_LWC1, OP_LWC3, OP_SWC0, OP_SWC1, OP_SWC3:
                r.exc = EXC_COPROC;
            default: r.exc = EXC_ILLEGAL;
        endcase
        return r;
    endfunction

    assign pending_count = expected_outcomes.size();

    // Predict on each input transfer, compare on each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        exec_outcome_t got;
        exec_outcome_t want;
        if (!rst_n)
        begin
            hi_copy = '0;
            lo_copy = '0;
            error_count <= 0;
            expected_outcomes.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_outcomes.push_back(execute_instr(instruction_word, rs_value,
                                                          rt_value, sequential_pc));
            if (out_valid && !out_stall)
            begin
                got = {write_enable, write_index, write_value, is_control_transfer,
                       redirect_taken, next_fetch_pc, exception_code, passed_on};
                if (expected_outcomes.size() == 0)
                begin
                    if (error_count < 10)
                        $display("mismatch: result with no instruction pending: %h", got);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got !== want)
                    begin
                        if (error_count < 10)
                            $display({"mismatch: we/idx/val exp %b/%0d/%h got %b/%0d/%h ",
                                      "ctl/tk/npc exp %b/%b/%h got %b/%b/%h ",
                                      "exc/pass exp %0d/%b got %0d/%b"},
                                     want.we, want.widx, want.wval,
                                     got.we, got.widx, got.wval,
                                     want.ctl, want.taken, want.npc,
                                     got.ctl, got.taken, got.npc,
                                     want.exc, want.pass, got.exc, got.pass);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

[dv/mips_integer_execute_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mips_integer_execute_unit_tb
// Drives directed and random instructions with random idling on both
// channels; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module mips_integer_execute_unit_tb;
    import mieu_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_COUNT = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instruction_word;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [31:0] sequential_pc;
    logic        out_valid;
    logic        out_stall;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic        is_control_transfer;
    logic        redirect_taken;
    logic [31:0] next_fetch_pc;
    logic [2:0]  exception_code;
    logic        passed_on;
    int          error_count;
    int          pending_count;
    int          cycle_count = 0;
    bit          idle_enable;
    bit          hold_off_request;

    mips_integer_execute_unit uut (.*);
    mips_integer_execute_unit_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stall the result channel in random bursts, or once for a long hold-off
    initial
    begin
        int burst;
        bit hold_off_seen;
        hold_off_seen = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_request && !hold_off_seen)
            begin
                hold_off_seen = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
            end
            burst = $urandom_range(1, 18);
            out_stall <= idle_enable && ($urandom_range(0, 2) == 0);
            repeat (burst) @(posedge clk);
        end
    end

    // Offer one instruction and hold it until transfer
    task automatic issue_instr(input logic [31:0] w, input logic [31:0] a,
                               input logic [31:0] b, input logic [31:0] seq);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        instruction_word <= w;
        rs_value         <= a;
        rt_value         <= b;
        sequential_pc    <= seq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return ALL_ONES;
            2: return SIGN_BIT;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [5:0] fn_codes[28] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
            FN_JR, FN_JALR, FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
            FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
            FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w[31:26] = OP_SPECIAL;
            4, 5:       w[31:26] = 6'($urandom_range(OP_REGIMM, OP_LUI));
            default:    w[31:26] = 6'($urandom);
        endcase
        if (w[31:26] == OP_SPECIAL && $urandom_range(0, 7) != 0)
            w[5:0] = fn_codes[$urandom_range(0, 27)];
        return w;
    endfunction

    // Stimulus
    initial
    begin
        logic [31:0] seq;
        in_valid         <= 1'b0;
        instruction_word <= '0;
        rs_value         <= '0;
        rt_value         <= '0;
        sequential_pc    <= '0;
        idle_enable      = 1'b1;
        hold_off_request = 1'b0;
        rst_n            <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: arithmetic extremes, division corner cases, HI/LO moves
        issue_instr({OP_SPECIAL, 20'h0, FN_MFHI}, 32'h0, 32'h0, 32'h0);
        issue_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD}, 32'h7FFF_FFFF, 32'd1, 32'h4);
        issue_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_ADD}, 32'd5, 32'd6, 32'h8);
        issue_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_SUB}, SIGN_BIT, 32'd1, 32'hC);
        issue_instr({OP_ADDI, 5'd1, 5'd4, 16'h8000}, SIGN_BIT, 32'h0, 32'h10);
        issue_instr({OP_SPECIAL, 20'h0, FN_DIV}, 32'hFFFF_FFF9, 32'h0, 32'h14);
        issue_instr({OP_SPECIAL, 10'h0, 5'd7, 5'd0, FN_MFLO}, 32'h0, 32'h0, 32'h18);
        issue_instr({OP_SPECIAL, 20'h0, FN_DIVU}, 32'h0000_0007, 32'h0, 32'h1C);
        issue_instr({OP_SPECIAL, 10'h0, 5'd8, 5'd0, FN_MFHI}, 32'h0, 32'h0, 32'h20);
        issue_instr({OP_SPECIAL, 20'h0, FN_DIV}, SIGN_BIT, ALL_ONES, 32'h24);
        issue_instr({OP_SPECIAL, 10'h0, 5'd8, 5'd0, FN_MFLO}, 32'h0, 32'h0, 32'h28);
        issue_instr({OP_SPECIAL, 20'h0, FN_MULT}, SIGN_BIT, ALL_ONES, 32'h2C);
        issue_instr({OP_SPECIAL, 10'h0, 5'd9, 5'd0, FN_MFHI}, 32'h0, 32'h0, 32'h30);
        issue_instr({OP_SPECIAL, 20'h0, FN_MTLO}, 32'hDEAD_BEEF, 32'h0, 32'h34);
        issue_instr({OP_SPECIAL, 10'h0, 5'd9, 5'd0, FN_MFLO}, 32'h0, 32'h0, 32'h38);
        // Directed: branches, jumps, links, special codes
        issue_instr({OP_REGIMM, 5'd1, 5'b10001, 16'hFFFF}, 32'h0, 32'h0, 32'hF000_0004);
        issue_instr({OP_REGIMM, 5'd1, 5'b10000, 16'h0001}, 32'h0, 32'h0, 32'h100);
        issue_instr({OP_BEQ, 10'h0, 16'h0001}, 32'h5, 32'h5, 32'h200);
        issue_instr({OP_JAL, 26'h3FF_FFFF}, 32'h0, 32'h0, 32'h0000_0000);
        issue_instr({OP_SPECIAL, 5'd4, 5'd0, 5'd31, 5'd0, FN_JALR}, 32'h1234_5679, 32'h0, 32'h40);
        issue_instr({OP_SPECIAL, 20'hFFFFF, FN_SYSCALL}, 32'h0, 32'h0, 32'h44);
        issue_instr({OP_SPECIAL, 20'h0, FN_BREAK}, 32'h0, 32'h0, 32'h48);
        issue_instr({OP_SPECIAL, 20'h0, 6'h3F}, 32'h0, 32'h0, 32'h4C);
        issue_instr({OP_LW, 26'h0}, 32'h0, 32'h0, 32'h50);
        issue_instr({OP_COP1, 26'h0}, 32'h0, 32'h0, 32'h54);
        issue_instr({6'h3F, 26'h0}, 32'h0, 32'h0, 32'h58);

        // Random; long receiver hold-off part way, sender drain pause later
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n == 60)
                hold_off_request = 1'b1;
            if (n == 200)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_count != 0) @(posedge clk);
            end
            if (n == RANDOM_COUNT - 60)
                idle_enable = 1'b0;
            seq = ($urandom_range(0, 3) == 0) ? {$urandom} : {$urandom} & ~32'h3;
            issue_instr(rand_instr(), rand_operand(), rand_operand(), seq);
        end
        in_valid <= 1'b0;

        // Drain, then let the block settle
        while (pending_count != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
